FILE: sv/ccr_pkg.sv
`default_nettype none
package ccr_pkg;
   localparam int CanvasWidth  = 64;
   localparam int CanvasHeight = 64;
   localparam int XW = $clog2(CanvasWidth)  > 0 ? $clog2(CanvasWidth)  : 1;
   localparam int YW = $clog2(CanvasHeight) > 0 ? $clog2(CanvasHeight) : 1;
   localparam int AW = XW + YW;
   localparam logic [7:0]  BLANK_PIXEL = 8'd32;
   localparam logic [15:0] TOL_RESET   = 16'd12;

   localparam logic [2:0] MODE_CLEAR  = 3'd0;
   localparam logic [2:0] MODE_POINT  = 3'd1;
   localparam logic [2:0] MODE_RECT   = 3'd2;
   localparam logic [2:0] MODE_FILL   = 3'd3;
   localparam logic [2:0] MODE_LINE   = 3'd4;
   localparam logic [2:0] MODE_RING   = 3'd5;
   localparam logic [2:0] MODE_DISK   = 3'd6;
   localparam logic [2:0] MODE_READ   = 3'd7;

   typedef struct packed {
      logic         we;
      logic [AW-1:0] addr;
      logic [7:0]   data;
   } wr_req_type;
endpackage
`default_nettype wire

FILE: sv/ccr_fb.sv
`default_nettype none
module ccr_fb (
   input  wire logic                 clock,
   input  ccr_pkg::wr_req_type       wr,
   input  wire logic [ccr_pkg::AW-1:0] rd_addr,
   output logic [7:0]                rd_data
);
   import ccr_pkg::*;
   logic [7:0] mem [0:(1<<AW)-1];
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: sv/ccr_seq.sv
`default_nettype none
// Sequencer: walks a pixel scan (x outer, y inner) or a line, one pixel test per cycle.
module ccr_seq (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [2:0]  mode,
   input  wire logic [7:0]  x_a,
   input  wire logic [7:0]  y_a,
   input  wire logic [7:0]  x_b,
   input  wire logic [7:0]  y_b,
   input  wire logic [7:0]  radius,
   input  wire logic [7:0]  pixel_char,
   input  wire logic [15:0] tol,
   output ccr_pkg::wr_req_type wr,
   output logic             busy,
   output logic             done
);
   import ccr_pkg::*;
   localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_LINE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  mode_ff;
   logic signed [10:0] x0_ff, x1_ff, y0_ff, y1_ff, x_ff, y_ff;
   logic signed [10:0] cx_ff, cy_ff;
   logic [7:0]  ch_ff;
   logic [15:0] rr_ff;
   logic        hx_en_ff, vy_en_ff;   // rectangle: horizontal / vertical edges drawn
   logic signed [11:0] m_ff, dy2_ff;
   logic signed [18:0] e_ff;
   logic        hit;
   logic signed [10:0] dx, dy;
   logic [16:0] d;
   logic signed [18:0] diff;
   logic [18:0] adiff;
   logic        on_canvas;
   logic        last;
   logic signed [18:0] e_step;

   assign dx = x_ff - cx_ff;
   assign dy = y_ff - cy_ff;
   // one shared squared-distance unit
   assign d = 17'(dx * dx) + 17'(dy * dy);
   always_comb begin
      diff = (mode_ff == MODE_RING) ? 19'(d) - 19'(rr_ff) : 19'(d) - 19'(tol);
      adiff = diff[18] ? 19'(-diff) : 19'(diff);
      unique case (mode_ff)
         MODE_CLEAR: hit = 1'b1;
         MODE_FILL:  hit = 1'b1;
         MODE_RECT:  hit = (vy_en_ff && ((x_ff == x0_ff) || (x_ff == x1_ff))) ||
                           (hx_en_ff && ((y_ff == y0_ff) || (y_ff == y1_ff)));
         MODE_RING:  hit = adiff <= 19'(tol);
         MODE_DISK:  hit = adiff <= 19'(rr_ff);
         default:    hit = 1'b1;
      endcase
   end
   assign on_canvas = x_ff >= 0 && y_ff >= 0 &&
                      x_ff < 11'(CanvasWidth) && y_ff < 11'(CanvasHeight);
   assign last = (x_ff == x1_ff) && (y_ff == y1_ff);
   assign e_step = e_ff + 19'(m_ff);

   always_comb begin
      wr.we   = (state_ff != S_IDLE) && on_canvas &&
                (state_ff == S_LINE || hit);
      wr.addr = {y_ff[YW-1:0], x_ff[XW-1:0]};
      wr.data = ch_ff;
   end

   always_comb begin
      state_in = state_ff;
      if (state_ff == S_IDLE && start) begin
         if (mode == MODE_READ) state_in = S_IDLE;
         else if (mode == MODE_LINE) state_in = (y_b < y_a) ? S_IDLE : S_LINE;
         else if (mode == MODE_RECT && x_a > x_b && y_a > y_b) state_in = S_IDLE;
         else if (mode == MODE_FILL && (x_a > x_b || y_a > y_b)) state_in = S_IDLE;
         else state_in = S_SCAN;
      end else if (state_ff == S_SCAN && last) begin
         state_in = S_IDLE;
      end else if (state_ff == S_LINE && y_ff == y1_ff) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SCAN;
         mode_ff  <= MODE_CLEAR;
         x_ff <= '0; y_ff <= '0; x0_ff <= '0; y0_ff <= '0;
         x1_ff <= 11'(CanvasWidth - 1); y1_ff <= 11'(CanvasHeight - 1);
         ch_ff <= BLANK_PIXEL;
         done <= 1'b0;
      end else begin
         state_ff <= state_in;
         done <= 1'b0;
         if (state_ff == S_IDLE && start) begin
            mode_ff <= mode;
            ch_ff   <= (mode == MODE_CLEAR) ? BLANK_PIXEL : pixel_char;
            rr_ff   <= 16'(radius * radius);
            hx_en_ff <= x_a <= x_b;
            vy_en_ff <= y_a <= y_b;
            cx_ff   <= 11'(x_a); cy_ff <= 11'(y_a);
            m_ff    <= 12'(2 * ($signed({1'b0, x_b}) - $signed({1'b0, x_a})));
            dy2_ff  <= 12'(2 * ($signed({1'b0, y_b}) - $signed({1'b0, y_a})));
            e_ff    <= 19'(2 * ($signed({1'b0, x_b}) - $signed({1'b0, x_a})) -
                          ($signed({1'b0, y_b}) - $signed({1'b0, y_a})));
            unique case (mode) inside
               MODE_CLEAR: begin
                  x0_ff <= '0; y0_ff <= '0; x_ff <= '0; y_ff <= '0;
                  x1_ff <= 11'(CanvasWidth - 1); y1_ff <= 11'(CanvasHeight - 1);
               end
               MODE_POINT: begin
                  x0_ff <= 11'(x_a); y0_ff <= 11'(y_a);
                  x_ff  <= 11'(x_a); y_ff  <= 11'(y_a);
                  x1_ff <= 11'(x_a); y1_ff <= 11'(y_a);
               end
               MODE_RECT: begin
                  // scan the box between the corners; edges gated by hx_en/vy_en
                  x0_ff <= 11'((x_a > x_b) ? x_b : x_a); y0_ff <= 11'((y_a > y_b) ? y_b : y_a);
                  x_ff  <= 11'((x_a > x_b) ? x_b : x_a); y_ff  <= 11'((y_a > y_b) ? y_b : y_a);
                  x1_ff <= 11'((x_a > x_b) ? x_a : x_b); y1_ff <= 11'((y_a > y_b) ? y_a : y_b);
               end
               MODE_RING, MODE_DISK: begin
                  x0_ff <= 11'(x_a) - 11'(radius); y0_ff <= 11'(y_a) - 11'(radius);
                  x_ff  <= 11'(x_a) - 11'(radius); y_ff  <= 11'(y_a) - 11'(radius);
                  x1_ff <= 11'(x_a) + 11'(radius); y1_ff <= 11'(y_a) + 11'(radius);
               end
               default: begin
                  x0_ff <= 11'(x_a); y0_ff <= 11'(y_a);
                  x_ff  <= 11'(x_a); y_ff  <= 11'(y_a);
                  x1_ff <= 11'(x_b); y1_ff <= 11'(y_b);
               end
            endcase
            if (state_in == S_IDLE) done <= 1'b1;
         end else if (state_ff == S_SCAN) begin
            if (last) begin
               done <= 1'b1;
            end else if (y_ff == y1_ff) begin
               y_ff <= y0_ff;
               x_ff <= x_ff + 11'sd1;
            end else begin
               y_ff <= y_ff + 11'sd1;
            end
         end else if (state_ff == S_LINE) begin
            y_ff <= y_ff + 11'sd1;
            if (e_step >= 0) begin
               x_ff <= x_ff + 11'sd1;
               e_ff <= e_step - 19'(dy2_ff);
            end else begin
               e_ff <= e_step;
            end
            if (y_ff == y1_ff) done <= 1'b1;
         end
      end
   end
   assign busy = state_ff != S_IDLE;
endmodule
`default_nettype wire

FILE: sv/char_canvas_rasterizer.sv
`default_nettype none
// Pixels scanned per command: clear scans all 4096, rectangles their box, circles a
//   (2r+1) square, lines one row a cycle; point one pixel, read and empty shapes none.
//   The sequencer tests one pixel per cycle and there is one write port.
// Throughput: one command at a time; req_ready low while a command runs or a response waits.
// Reset: runs a clearing pass writing space into every pixel, with req_ready low;
//   the tolerance register tol_ff resets to 12.
module char_canvas_rasterizer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_mode,
   input  wire logic [7:0] req_x_a,
   input  wire logic [7:0] req_y_a,
   input  wire logic [7:0] req_x_b,
   input  wire logic [7:0] req_y_b,
   input  wire logic [7:0] req_radius,
   input  wire logic [7:0] req_pixel_char,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   input  wire logic       csr_we,
   input  wire logic [15:0] csr_wdata
);
   import ccr_pkg::*;

   logic [15:0] tol_ff;
   logic        start, busy, done;
   wr_req_type  wr;
   logic [7:0]  rd_data;
   logic        rd_pend_ff, rd_ok_ff;   // read accepted last cycle; its address on canvas
   logic        pend_ff;                // command in flight
   logic [AW-1:0] rd_addr;

   assign req_ready = !busy && !pend_ff && !rsp_valid;
   assign start = req_valid && req_ready;
   assign rd_addr = {req_y_a[YW-1:0], req_x_a[XW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_RESET;
      else if (csr_we) tol_ff <= csr_wdata;
   end

   ccr_seq u_seq (
      .clock, .reset, .start, .mode(req_mode), .x_a(req_x_a), .y_a(req_y_a),
      .x_b(req_x_b), .y_b(req_y_b), .radius(req_radius),
      .pixel_char(req_pixel_char), .tol(tol_ff), .wr, .busy, .done
   );

   ccr_fb u_fb (.clock, .wr, .rd_addr, .rd_data);

   // the frame buffer returns read data in the cycle after the address is presented
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0; rd_pend_ff <= 1'b0; rsp_valid <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         rd_pend_ff  <= start && req_mode == MODE_READ;
         rd_ok_ff    <= 9'(req_x_a) < 9'(CanvasWidth) && 9'(req_y_a) < 9'(CanvasHeight);
         if (start) pend_ff <= 1'b1;
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         if (rd_pend_ff) begin
            rsp_valid <= 1'b1;
            rsp_read_data <= rd_ok_ff ? rd_data : 8'd0;
            pend_ff <= 1'b0;
         end else if (done && pend_ff) begin
            rsp_valid <= 1'b1;
            rsp_read_data <= 8'd0;
            pend_ff <= 1'b0;
         end
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready) else $error("accept while busy");
   a_read_resp: assert property (@(posedge clock) disable iff (reset)
      (start && req_mode == MODE_READ) |=> ##1 rsp_valid) else $error("read lost");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr.we |-> busy) else $error("write while idle");
endmodule
`default_nettype wire

FILE: tb/sv/char_canvas_rasterizer_tb.sv
`timescale 1ns / 1ps
module char_canvas_rasterizer_tb;
   import ccr_pkg::*;

   // one drawing command as presented on the req_ channel
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] x_a;
      logic [7:0] y_a;
      logic [7:0] x_b;
      logic [7:0] y_b;
      logic [7:0] radius;
      logic [7:0] pixel_char;
   } draw_cmd_type;

   localparam longint CycleLimit = 200_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = MODE_CLEAR;
   logic [7:0]  req_x_a = '0, req_y_a = '0, req_x_b = '0, req_y_b = '0;
   logic [7:0]  req_radius = '0, req_pixel_char = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   // shadow canvas, updated at every accepted request, and circle tolerance, set at each CSR write
   logic [7:0]  shadow_canvas [CanvasWidth*CanvasHeight];
   logic [15:0] shadow_tolerance;

   draw_cmd_type pending_cmds[$];
   logic [7:0]  expected_pixels[$];
   int          fail_count = 0;
   int          send_gap = 0;
   int          recv_stall = 0;
   bit          no_idle = 1'b0;   // when set, neither side inserts gaps
   longint      cycle_count = 0;
   logic [2:0]  mode_pick [7] = '{MODE_POINT, MODE_RECT, MODE_FILL, MODE_LINE,
                                  MODE_RING, MODE_DISK, MODE_CLEAR};

   char_canvas_rasterizer uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_x_a, .req_y_a, .req_x_b, .req_y_b,
      .req_radius, .req_pixel_char,
      .rsp_valid, .rsp_ready, .rsp_read_data,
      .csr_we, .csr_wdata
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- canvas predictor ----------------
   function automatic void put_pixel(int col, int row, logic [7:0] ch);
      if (col >= 0 && row >= 0 && col < CanvasWidth && row < CanvasHeight)
         shadow_canvas[row*CanvasWidth + col] = ch;
   endfunction

   function automatic void blank_canvas();
      foreach (shadow_canvas[k]) shadow_canvas[k] = BLANK_PIXEL;
   endfunction

   // applies one command to the shadow canvas, returns the expected read byte
   function automatic logic [7:0] draw_and_predict(draw_cmd_type c);
      int xa = c.x_a, ya = c.y_a, xb = c.x_b, yb = c.y_b, r = c.radius;
      int slope, err, col;
      longint rr, sq_dist, tol, diff;
      logic [7:0] rd = '0;
      case (c.mode)
         MODE_CLEAR: blank_canvas();
         MODE_POINT: put_pixel(xa, ya, c.pixel_char);
         MODE_RECT: begin
            for (int i = xa; i <= xb; i++) begin
               put_pixel(i, ya, c.pixel_char);
               put_pixel(i, yb, c.pixel_char);
            end
            for (int i = ya; i <= yb; i++) begin
               put_pixel(xb, i, c.pixel_char);
               put_pixel(xa, i, c.pixel_char);
            end
         end
         MODE_FILL:
            for (int i = xa; i <= xb; i++)
               for (int j = ya; j <= yb; j++) put_pixel(i, j, c.pixel_char);
         MODE_LINE: begin
            // row-stepping walk; column only ever moves right
            slope = 2*(xb - xa);
            err = slope - (yb - ya);
            col = xa;
            for (int row = ya; row <= yb; row++) begin
               put_pixel(col, row, c.pixel_char);
               err += slope;
               if (err >= 0) begin
                  col++;
                  err -= 2*(yb - ya);
               end
            end
         end
         MODE_RING, MODE_DISK: begin
            rr = longint'(r) * r;
            tol = shadow_tolerance;
            for (int cx = xa - r; cx <= xa + r; cx++)
               for (int cy = ya - r; cy <= ya + r; cy++) begin
                  sq_dist = longint'(cx - xa)*(cx - xa) + longint'(cy - ya)*(cy - ya);
                  if (c.mode == MODE_RING) begin
                     diff = sq_dist - rr;
                     if (diff < 0) diff = -diff;
                     if (diff <= tol) put_pixel(cx, cy, c.pixel_char);
                  end else begin
                     diff = sq_dist - tol;
                     if (diff < 0) diff = -diff;
                     if (diff <= rr) put_pixel(cx, cy, c.pixel_char);
                  end
               end
         end
         default:
            if (xa < CanvasWidth && ya < CanvasHeight)
               rd = shadow_canvas[ya*CanvasWidth + xa];
      endcase
      return rd;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic draw_cmd_type mk_cmd(logic [2:0] m, int xa, int ya, int xb, int yb,
                                           int r, int ch);
      draw_cmd_type c;
      c.mode = m; c.x_a = 8'(xa); c.y_a = 8'(ya); c.x_b = 8'(xb); c.y_b = 8'(yb);
      c.radius = 8'(r); c.pixel_char = 8'(ch);
      return c;
   endfunction

   // mostly on-canvas, sometimes anywhere in the 8-bit range
   function automatic int rand_coord();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 63) : $urandom_range(0, 255);
   endfunction

   function automatic draw_cmd_type rand_cmd();
      draw_cmd_type c;
      int t;
      c.x_a = 8'(rand_coord()); c.y_a = 8'(rand_coord());
      c.x_b = 8'(rand_coord()); c.y_b = 8'(rand_coord());
      c.pixel_char = 8'($urandom_range(0, 255));
      c.radius = 8'(($urandom_range(0, 99) < 93) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 255));
      if ($urandom_range(0, 99) < 35) begin
         c.mode = MODE_READ;
      end else begin
         c.mode = mode_pick[$urandom_range(0, 6)];
         if (c.mode == MODE_CLEAR && $urandom_range(0, 2) != 0) c.mode = MODE_POINT;
      end
      // mostly well-ordered corners so shapes actually draw
      if ((c.mode == MODE_RECT || c.mode == MODE_FILL || c.mode == MODE_LINE)
          && $urandom_range(0, 9) < 8) begin
         if (c.x_a > c.x_b) begin t = c.x_a; c.x_a = c.x_b; c.x_b = 8'(t); end
         if (c.y_a > c.y_b) begin t = c.y_a; c.y_a = c.y_b; c.y_b = 8'(t); end
      end
      return c;
   endfunction

   task automatic wait_idle();
      // sampled mid-cycle so driver updates at the edge have settled
      while (pending_cmds.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      shadow_tolerance = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_random(int n);
      repeat (n) pending_cmds.push_back(rand_cmd());
   endtask

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(draw_and_predict(
               {req_mode, req_x_a, req_y_a, req_x_b, req_y_b, req_radius, req_pixel_char}));
            req_valid <= 1'b0;
            send_gap <= no_idle ? 0 : $urandom_range(0, 9);
         end else if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (pending_cmds.size() != 0) begin
               draw_cmd_type c;
               c = pending_cmds.pop_front();
               req_mode <= c.mode;
               req_x_a <= c.x_a; req_y_a <= c.y_a;
               req_x_b <= c.x_b; req_y_b <= c.y_b;
               req_radius <= c.radius;
               req_pixel_char <= c.pixel_char;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // ---------------- response monitor ----------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("rsp transfer with no command outstanding: read_data=%0d", rsp_read_data);
               fail_count++;
            end else begin
               logic [7:0] want;
               want = expected_pixels.pop_front();
               if (rsp_read_data !== want) begin
                  $error("read_data: expected %0d, got %0d", want, rsp_read_data);
                  fail_count++;
               end
            end
            recv_stall = no_idle ? 0 : $urandom_range(0, 9);
            rsp_ready <= (recv_stall == 0);
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= (recv_stall == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------- test sequence ----------------
   initial begin
      blank_canvas();
      shadow_tolerance = TOL_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, off-canvas, every mode, reversed shapes, edge cases
      pending_cmds.push_back(mk_cmd(MODE_POINT, 0, 0, 0, 0, 0, 255));
      pending_cmds.push_back(mk_cmd(MODE_POINT, 63, 63, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(MODE_POINT, 64, 0, 255, 255, 255, 65));
      pending_cmds.push_back(mk_cmd(MODE_POINT, 255, 255, 0, 0, 0, 66));
      pending_cmds.push_back(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(MODE_READ, 63, 63, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(MODE_READ, 200, 10, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(MODE_RECT, 2, 3, 10, 12, 0, 35));
      pending_cmds.push_back(mk_cmd(MODE_RECT, 20, 5, 10, 9, 0, 36));   // left > right
      pending_cmds.push_back(mk_cmd(MODE_RECT, 5, 30, 9, 20, 0, 37));   // top > bottom
      pending_cmds.push_back(mk_cmd(MODE_FILL, 40, 40, 70, 70, 0, 38)); // clipped
      pending_cmds.push_back(mk_cmd(MODE_FILL, 30, 10, 20, 15, 0, 39)); // reversed
      pending_cmds.push_back(mk_cmd(MODE_LINE, 1, 20, 30, 40, 0, 40));
      pending_cmds.push_back(mk_cmd(MODE_LINE, 5, 50, 30, 45, 0, 41));  // ends above start
      pending_cmds.push_back(mk_cmd(MODE_LINE, 50, 10, 30, 25, 0, 42)); // going left
      pending_cmds.push_back(mk_cmd(MODE_LINE, 10, 60, 10, 60, 0, 43)); // single point
      pending_cmds.push_back(mk_cmd(MODE_RING, 32, 32, 0, 0, 10, 44));
      pending_cmds.push_back(mk_cmd(MODE_RING, 5, 5, 0, 0, 0, 45));
      pending_cmds.push_back(mk_cmd(MODE_DISK, 0, 63, 0, 0, 6, 46));
      pending_cmds.push_back(mk_cmd(MODE_DISK, 32, 32, 0, 0, 128, 47));
      pending_cmds.push_back(mk_cmd(MODE_READ, 32, 32, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(MODE_READ, 20, 30, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
      queue_random(20);
      wait_idle();

      write_tolerance(16'd0);
      no_idle = 1'b1;
      queue_random(25);
      wait_idle();

      write_tolerance(16'hFFFF);
      no_idle = 1'b0;
      queue_random(25);
      wait_idle();

      write_tolerance(16'($urandom_range(0, 200)));
      queue_random(25);
      wait_idle();

      write_tolerance(TOL_RESET);
      queue_random(20);
      wait_idle();

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
